[hdl/lbpm_pkg.sv]
// Shared constants and types of the light bar pair matcher.
package lbpm_pkg;

    localparam int MAX_BARS    = 32;
    localparam int MAX_RESULTS = 32;

    localparam int IDX_W  = (MAX_BARS > 2) ? $clog2(MAX_BARS) : 1;
    localparam int CNT_W  = $clog2(MAX_BARS + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int OUT_W  = 5;
    localparam int WIDE_W = (IDX_W > OUT_W) ? IDX_W : OUT_W;

    localparam int ROW_W   = 10;
    localparam int SLOPE_W = 24;
    localparam int VTOL_W  = 10;
    localparam int STOL_W  = 23;
    localparam int KTOL_W  = 11;
    localparam int THR_W   = 3;
    localparam int CFG_W   = 23;
    localparam int CFGI_W  = 2;
    localparam int DIFF_W  = 26;
    localparam int RDIF_W  = 11;

    localparam logic [CFGI_W-1:0] CFG_VERT  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_SLOPE = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_SKEW  = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_THR   = 2'd3;

    localparam logic [VTOL_W-1:0] VERT_RST  = 10'd50;
    localparam logic [STOL_W-1:0] SLOPE_RST = 23'd1280000;
    localparam logic [KTOL_W-1:0] SKEW_RST  = 11'd50;
    localparam logic [THR_W-1:0]  THR_RST   = 3'd2;

    // Test phases of the shared difference unit.
    localparam logic [1:0] PH_TOP    = 2'd0;
    localparam logic [1:0] PH_BOTTOM = 2'd1;
    localparam logic [1:0] PH_SLOPE  = 2'd2;
    localparam logic [1:0] PH_SKEW   = 2'd3;

    // One stored bar; the slope is kept as its magnitude since only that is compared.
    typedef struct packed {
        logic [ROW_W-1:0]   top;
        logic [ROW_W-1:0]   bottom;
        logic [SLOPE_W-1:0] mag;
    } t_entry;

endpackage

[hdl/lbpm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/light_bar_pair_matcher.sv]
// Top level of the light bar pair matcher: bar store, pair search sequencer, result port.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------------
//  bar in   | start & !busy         | i_bar_top_row, i_bar_bottom_row, i_bar_slope,
//           |                       | i_bar_last
//  result   | o_strobe, one cycle   | o_pair_valid, o_first_bar, o_second_bar,
//           |                       | o_last_result
//  config   | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// A bar without the last mark is stored while the store has room, and busy stays low.
// A frame end starts the search: each earlier bar is latched in turn, then each
// compared pair runs through the single shared difference and compare unit, and a
// flush state sends the final result. The store needs no clearing after reset.
// Results come out of output registers and the receiver cannot stall them.
module light_bar_pair_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lbpm_pkg::ROW_W-1:0]          i_bar_top_row,
    input  logic [lbpm_pkg::ROW_W-1:0]          i_bar_bottom_row,
    input  logic signed [lbpm_pkg::SLOPE_W-1:0] i_bar_slope,
    input  logic                                i_bar_last,
    output logic                                o_strobe,
    output logic                                o_pair_valid,
    output logic [lbpm_pkg::OUT_W-1:0]          o_first_bar,
    output logic [lbpm_pkg::OUT_W-1:0]          o_second_bar,
    output logic                                o_last_result,
    input  logic                                i_cfg_we,
    input  logic [lbpm_pkg::CFGI_W-1:0]         i_cfg_idx,
    input  logic [lbpm_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LATI  = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam int IW = lbpm_pkg::IDX_W;
    localparam int CW = lbpm_pkg::CNT_W;
    localparam int DW = lbpm_pkg::DIFF_W;

    // Control state.
    logic [1:0]                 r_state,      n_state;
    logic [CW-1:0]              r_bar_count,  n_bar_count;
    logic [CW-1:0]              r_nbars,      n_nbars;
    logic [IW-1:0]              r_i,          n_i;
    logic [IW-1:0]              r_j,          n_j;
    logic [1:0]                 r_phase,      n_phase;
    logic                       r_have_pend,  n_have_pend;
    logic [lbpm_pkg::RES_W-1:0] r_npairs,     n_npairs;
    logic                       r_strobe,     n_strobe;

    // Configuration.
    logic [lbpm_pkg::VTOL_W-1:0] r_vert_tol;
    logic [lbpm_pkg::STOL_W-1:0] r_slope_tol;
    logic [lbpm_pkg::KTOL_W-1:0] r_skew_tol;
    logic [lbpm_pkg::THR_W-1:0]  r_thr;

    // Payload.
    logic [2:0]                         r_score,   n_score;
    logic signed [lbpm_pkg::RDIF_W-1:0] r_td,      n_td;
    logic signed [lbpm_pkg::RDIF_W-1:0] r_bd,      n_bd;
    lbpm_pkg::t_entry                   r_bar_i,   n_bar_i;
    logic [IW-1:0]                      r_pend_i,  n_pend_i;
    logic [IW-1:0]                      r_pend_j,  n_pend_j;
    logic                               r_valid,   n_valid;
    logic [lbpm_pkg::OUT_W-1:0]         r_first,   n_first;
    logic [lbpm_pkg::OUT_W-1:0]         r_second,  n_second;
    logic                               r_last,    n_last;

    // Store ports.
    logic             we;
    logic             re;
    logic [IW-1:0]    raddr;
    lbpm_pkg::t_entry wentry;
    lbpm_pkg::t_entry rentry;

    logic                       accept;
    logic [lbpm_pkg::SLOPE_W:0] slope_ext;
    logic [lbpm_pkg::SLOPE_W:0] slope_neg;
    logic [CW-1:0]              frame_bars;

    // Shared difference unit.
    logic signed [DW-1:0] ux, uy, ud, umag;
    logic [DW-1:0]        utol;
    logic                 upass;
    logic [2:0]           score_total;
    logic                 found;
    logic [CW:0]          i_next2;
    logic [CW:0]          j_next1;
    logic                 more_i;
    logic                 more_j;
    logic [lbpm_pkg::RES_W-1:0] npairs_inc;

    // Low bits of a bar index as reported on the result ports.
    function automatic logic [lbpm_pkg::OUT_W-1:0] WIDE_OUT(input logic [IW-1:0] idx);
        logic [lbpm_pkg::WIDE_W-1:0] wide;
        wide = lbpm_pkg::WIDE_W'(idx);
        return wide[lbpm_pkg::OUT_W-1:0];
    endfunction

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    assign slope_ext = {i_bar_slope[lbpm_pkg::SLOPE_W-1], i_bar_slope};
    assign slope_neg = -slope_ext;
    assign wentry.top    = i_bar_top_row;
    assign wentry.bottom = i_bar_bottom_row;
    assign wentry.mag    = slope_ext[lbpm_pkg::SLOPE_W] ?
                           slope_neg[lbpm_pkg::SLOPE_W-1:0] :
                           slope_ext[lbpm_pkg::SLOPE_W-1:0];

    assign we = accept && (r_bar_count < CW'(lbpm_pkg::MAX_BARS));
    assign frame_bars = we ? r_bar_count + CW'(1) : r_bar_count;

    lbpm_ram #(
        .WIDTH ($bits(lbpm_pkg::t_entry)),
        .DEPTH (lbpm_pkg::MAX_BARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_bar_count[IW-1:0]),
        .i_wdata (wentry),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rentry)
    );

    // The skew test reuses the stored differences: td - (-bd) is td + bd.
    always_comb begin
        case (r_phase)
            lbpm_pkg::PH_TOP: begin
                ux   = DW'({1'b0, r_bar_i.top});
                uy   = DW'({1'b0, rentry.top});
                utol = DW'(r_vert_tol);
            end
            lbpm_pkg::PH_BOTTOM: begin
                ux   = DW'({1'b0, r_bar_i.bottom});
                uy   = DW'({1'b0, rentry.bottom});
                utol = DW'(r_vert_tol);
            end
            lbpm_pkg::PH_SLOPE: begin
                ux   = DW'({1'b0, r_bar_i.mag});
                uy   = DW'({1'b0, rentry.mag});
                utol = DW'(r_slope_tol);
            end
            default: begin
                ux   = DW'(r_td);
                uy   = -DW'(r_bd);
                utol = DW'(r_skew_tol);
            end
        endcase
    end

    assign ud    = ux - uy;
    assign umag  = ud[DW-1] ? -ud : ud;
    assign upass = ($unsigned(umag) < utol);

    assign score_total = r_score + {2'b00, upass};
    assign found       = (score_total > r_thr);
    assign i_next2     = (CW+1)'(r_i) + (CW+1)'(2);
    assign j_next1     = (CW+1)'(r_j) + (CW+1)'(1);
    assign more_i      = (i_next2 < (CW+1)'(r_nbars));
    assign more_j      = (j_next1 < (CW+1)'(r_nbars));
    assign npairs_inc  = r_npairs + lbpm_pkg::RES_W'(1);

    always_comb begin
        n_state     = r_state;
        n_bar_count = r_bar_count;
        n_nbars     = r_nbars;
        n_i         = r_i;
        n_j         = r_j;
        n_phase     = r_phase;
        n_have_pend = r_have_pend;
        n_npairs    = r_npairs;
        n_strobe    = 1'b0;
        n_score     = r_score;
        n_td        = r_td;
        n_bd        = r_bd;
        n_bar_i     = r_bar_i;
        n_pend_i    = r_pend_i;
        n_pend_j    = r_pend_j;
        n_valid     = r_valid;
        n_first     = r_first;
        n_second    = r_second;
        n_last      = r_last;
        re          = 1'b0;
        raddr       = r_i;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_bar_count = frame_bars;
                    if (i_bar_last) begin
                        n_nbars     = frame_bars;
                        n_i         = '0;
                        n_have_pend = 1'b0;
                        n_npairs    = '0;
                        if (frame_bars >= CW'(2)) begin
                            re      = 1'b1;
                            raddr   = '0;
                            n_state = ST_LATI;
                        end else begin
                            n_state = ST_FLUSH;
                        end
                    end
                end
            end
            ST_LATI: begin
                n_bar_i = rentry;
                re      = 1'b1;
                raddr   = r_i + IW'(1);
                n_j     = r_i + IW'(1);
                n_phase = lbpm_pkg::PH_TOP;
                n_score = '0;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_score = score_total;
                n_phase = r_phase + 2'd1;
                if (r_phase == lbpm_pkg::PH_TOP) begin
                    n_td = ud[lbpm_pkg::RDIF_W-1:0];
                end
                if (r_phase == lbpm_pkg::PH_BOTTOM) begin
                    n_bd = ud[lbpm_pkg::RDIF_W-1:0];
                end
                if (r_phase == lbpm_pkg::PH_SKEW) begin
                    n_score = '0;
                    if (found) begin
                        // The held pair is not the frame's last one, so it goes out now.
                        if (r_have_pend) begin
                            n_strobe = 1'b1;
                            n_valid  = 1'b1;
                            n_first  = WIDE_OUT(r_pend_i);
                            n_second = WIDE_OUT(r_pend_j);
                            n_last   = 1'b0;
                        end
                        n_have_pend = 1'b1;
                        n_pend_i    = r_i;
                        n_pend_j    = r_j;
                        n_npairs    = npairs_inc;
                        if (more_i && npairs_inc != lbpm_pkg::RES_W'(lbpm_pkg::MAX_RESULTS)) begin
                            re      = 1'b1;
                            raddr   = r_i + IW'(1);
                            n_i     = r_i + IW'(1);
                            n_state = ST_LATI;
                        end else begin
                            n_state = ST_FLUSH;
                        end
                    end else if (more_j) begin
                        re      = 1'b1;
                        raddr   = r_j + IW'(1);
                        n_j     = r_j + IW'(1);
                    end else if (more_i) begin
                        re      = 1'b1;
                        raddr   = r_i + IW'(1);
                        n_i     = r_i + IW'(1);
                        n_state = ST_LATI;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                n_strobe    = 1'b1;
                n_last      = 1'b1;
                n_valid     = r_have_pend;
                n_first     = r_have_pend ? WIDE_OUT(r_pend_i) : '0;
                n_second    = r_have_pend ? WIDE_OUT(r_pend_j) : '0;
                n_have_pend = 1'b0;
                n_bar_count = '0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bar_count <= '0;
            r_nbars     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_phase     <= lbpm_pkg::PH_TOP;
            r_have_pend <= 1'b0;
            r_npairs    <= '0;
            r_strobe    <= 1'b0;
            r_vert_tol  <= lbpm_pkg::VERT_RST;
            r_slope_tol <= lbpm_pkg::SLOPE_RST;
            r_skew_tol  <= lbpm_pkg::SKEW_RST;
            r_thr       <= lbpm_pkg::THR_RST;
        end else begin
            r_state     <= n_state;
            r_bar_count <= n_bar_count;
            r_nbars     <= n_nbars;
            r_i         <= n_i;
            r_j         <= n_j;
            r_phase     <= n_phase;
            r_have_pend <= n_have_pend;
            r_npairs    <= n_npairs;
            r_strobe    <= n_strobe;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lbpm_pkg::CFG_VERT:  r_vert_tol  <= i_cfg_data[lbpm_pkg::VTOL_W-1:0];
                    lbpm_pkg::CFG_SLOPE: r_slope_tol <= i_cfg_data[lbpm_pkg::STOL_W-1:0];
                    lbpm_pkg::CFG_SKEW:  r_skew_tol  <= i_cfg_data[lbpm_pkg::KTOL_W-1:0];
                    lbpm_pkg::CFG_THR:   r_thr       <= i_cfg_data[lbpm_pkg::THR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_score  <= n_score;
        r_td     <= n_td;
        r_bd     <= n_bd;
        r_bar_i  <= n_bar_i;
        r_pend_i <= n_pend_i;
        r_pend_j <= n_pend_j;
        r_valid  <= n_valid;
        r_first  <= n_first;
        r_second <= n_second;
        r_last   <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_pair_valid  = r_valid;
    assign o_first_bar   = r_first;
    assign o_second_bar  = r_second;
    assign o_last_result = r_last;

endmodule
